@@ rtl/text_console_writer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the checker of the text console writer.
// Every property is clocked by clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and control/status types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths of the item and result transactions.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Width of a screen memory address.
  localparam int CNT_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic home;
    logic step;
    logic cnt_zero;
    logic cnt_inc;
    logic fill_wr;
    logic fill_init;
    logic put_wr;
    logic rd_cell;
    logic copy_rd;
    logic copy_wr;
    logic val_clear;
    logic val_load;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic newline;
    logic scroll_need;
    logic idx_ok;
    logic fill_last;
    logic copy_end;
    logic cnt_is_zero;
  } tcw_sts_t;

endpackage

@@ rtl/tcw_datapath.sv @@
// ---------------------------------------------------------------------------
// tcw_datapath
// Screen memory, sweep counter, cursor registers and read value register.
// ---------------------------------------------------------------------------
module tcw_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::tcw_cmd_t            ctl_i,
  input  logic [tcw_pkg::CMD_W-1:0]    cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]    cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr_i,
  output tcw_pkg::tcw_sts_t            sts_o,
  output logic [tcw_pkg::POS_W-1:0]    pos_o,
  output logic [tcw_pkg::COL_W-1:0]    col_o,
  output logic [tcw_pkg::ROW_W-1:0]    row_o,
  output logic [tcw_pkg::CELL_W-1:0]   value_o
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

  tcw_pkg::cmd_e                cmd_q;
  logic [tcw_pkg::CHAR_W-1:0]   char_q;
  logic [tcw_pkg::POS_W-1:0]    idx_q;
  logic [tcw_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [tcw_pkg::COL_W-1:0]    col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]    row_q, row_d;
  logic [tcw_pkg::CELL_W-1:0]   value_q, value_d;
  logic [tcw_pkg::CELL_W-1:0]   rdata_q;

  logic                         we, re;
  logic [tcw_pkg::CNT_W-1:0]    waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0]   wdata;
  logic [tcw_pkg::POS_W-1:0]    pos;
  logic                         newline, adv_row, last_row;

  assign pos      = tcw_pkg::POS_W'(int'(row_q) * tcw_pkg::COLUMNS + int'(col_q));
  assign newline  = (char_q == tcw_pkg::NEWLINE_CHAR);
  assign adv_row  = newline || (int'(col_q) == tcw_pkg::COLUMNS - 1);
  assign last_row = (int'(row_q) == tcw_pkg::ROWS - 1);

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.newline     = newline;
    sts_o.scroll_need = adv_row && last_row;
    sts_o.idx_ok      = (int'(idx_q) < tcw_pkg::CELLS);
    sts_o.fill_last   = (int'(cnt_q) == tcw_pkg::CELLS - 1);
    sts_o.copy_end    = (int'(cnt_q) == tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    sts_o.cnt_is_zero = (cnt_q == '0);
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = {attr_i, tcw_pkg::SPACE_CHAR};
    re    = 1'b0;
    raddr = tcw_pkg::CNT_W'(int'(cnt_q) + tcw_pkg::COLUMNS);
    if (ctl_i.fill_wr) begin
      we = 1'b1;
      if (ctl_i.fill_init) begin
        wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
      end
    end else if (ctl_i.put_wr) begin
      we    = 1'b1;
      waddr = tcw_pkg::CNT_W'(pos);
      wdata = {attr_i, char_q};
    end else if (ctl_i.copy_wr) begin
      we    = 1'b1;
      waddr = cnt_q - tcw_pkg::CNT_W'(1);
      wdata = rdata_q;
    end
    if (ctl_i.rd_cell) begin
      re    = 1'b1;
      raddr = tcw_pkg::CNT_W'(idx_q);
    end else if (ctl_i.copy_rd) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q  <= tcw_pkg::cmd_e'(cmd_i);
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.cnt_zero) begin
      cnt_d = '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + tcw_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctl_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (ctl_i.step) begin
      if (adv_row) begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + tcw_pkg::ROW_W'(1);
        end
      end else begin
        col_d = col_q + tcw_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    value_d = value_q;
    if (ctl_i.val_clear) begin
      value_d = '0;
    end else if (ctl_i.val_load) begin
      value_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign pos_o   = pos;
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign value_o = value_q;

endmodule

@@ rtl/tcw_ctrl.sv @@
// ---------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine sequencing commands, sweeps and result hand-off.
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t ctl_o,
  output logic              in_ready_o,
  output logic              out_load_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_COPY,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctl_o.fill_wr   = 1'b1;
        ctl_o.fill_init = 1'b1;
        if (sts_i.fill_last) begin
          ctl_o.cnt_zero = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          ctl_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.val_clear = 1'b1;
        case (sts_i.cmd)
          tcw_pkg::CMD_CLEAR: begin
            ctl_o.home     = 1'b1;
            ctl_o.cnt_zero = 1'b1;
            state_d        = ST_FILL;
          end
          tcw_pkg::CMD_PUT: begin
            ctl_o.step   = 1'b1;
            ctl_o.put_wr = !sts_i.newline;
            if (sts_i.scroll_need) begin
              ctl_o.cnt_zero = 1'b1;
              state_d        = ST_COPY;
            end else begin
              state_d = ST_DONE;
            end
          end
          tcw_pkg::CMD_READ: begin
            if (sts_i.idx_ok) begin
              ctl_o.rd_cell = 1'b1;
              state_d       = ST_RDWAIT;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        ctl_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_DONE;
        end else begin
          ctl_o.cnt_inc = 1'b1;
        end
      end
      ST_COPY: begin
        ctl_o.copy_rd = !sts_i.copy_end;
        ctl_o.copy_wr = !sts_i.cnt_is_zero;
        if (sts_i.copy_end) begin
          state_d = ST_FILL;
        end else begin
          ctl_o.cnt_inc = 1'b1;
        end
      end
      ST_RDWAIT: begin
        ctl_o.val_load = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/text_console_writer.sv @@
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console with an 80 by 25 cell screen, cursor and scrolling.
//
//   Channel   Handshake                  Payload
//   input     in_valid_i / in_ready_o    cmd_i, char_code_i, cell_index_i
//   result    out_valid_o / out_ready_i  cursor_pos_o, cursor_col_o,
//                                        cursor_row_o, cell_value_o
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A put, read or unused command passes through accept, execute and hand-off
// states before the block is ready again; hand-off waits until the output
// register is free, and a read adds a state for the registered memory read.
// A clear adds a fill pass, one memory write per cell. A put that leaves the
// bottom row scrolls: the copy loop moves one cell per cycle through the
// single read and single write port, then blanks the bottom row. After reset
// a clearing pass writes every cell once before the first transaction is
// accepted. A result waits in the output register while the next item is
// taken.
// ---------------------------------------------------------------------------
module text_console_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]   cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]   cell_index_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]   cursor_pos_o,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::CELL_W-1:0]  cell_value_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // The attribute register sits at byte address zero; any address with
  // bit 2 set lies beyond the register list and is ignored.
  logic [tcw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                       attr_sel;

  assign pready   = 1'b1;
  assign attr_sel = !paddr[2];

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && attr_sel) begin
      attr_d = pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  assign prdata = attr_sel ? {{(32 - tcw_pkg::ATTR_W){1'b0}}, attr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::RESET_ATTR;
    end else begin
      attr_q <= attr_d;
    end
  end

  // Controller and datapath.
  tcw_pkg::tcw_cmd_t          ctl;
  tcw_pkg::tcw_sts_t          sts;
  logic                       out_free, out_load;
  logic [tcw_pkg::POS_W-1:0]  dp_pos;
  logic [tcw_pkg::COL_W-1:0]  dp_col;
  logic [tcw_pkg::ROW_W-1:0]  dp_row;
  logic [tcw_pkg::CELL_W-1:0] dp_value;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load)
  );

  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .sts_o        (sts),
    .pos_o        (dp_pos),
    .col_o        (dp_col),
    .row_o        (dp_row),
    .value_o      (dp_value)
  );

  // Output register: it holds a finished result until the consumer takes
  // it, and it can be refilled in the same cycle that it drains.
  logic                       out_valid_q, out_valid_d;
  logic [tcw_pkg::POS_W-1:0]  pos_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::CELL_W-1:0] value_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q   <= dp_pos;
      col_q   <= dp_col;
      row_q   <= dp_row;
      value_q <= dp_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign cell_value_o = value_q;

endmodule

@@ rtl/text_console_writer_sva.sv @@
// ---------------------------------------------------------------------------
// text_console_writer_sva
// Port-level checker for the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer_sva (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tcw_pkg::POS_W-1:0]   cursor_pos_o,
  input logic [tcw_pkg::COL_W-1:0]   cursor_col_o,
  input logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  input logic [tcw_pkg::CELL_W-1:0]  cell_value_o
);

  logic col_ok, row_ok, pos_ok;

  assign col_ok = (int'(cursor_col_o) < tcw_pkg::COLUMNS);
  assign row_ok = (int'(cursor_row_o) < tcw_pkg::ROWS);
  assign pos_ok = (int'(cursor_pos_o) ==
                   int'(cursor_row_o) * tcw_pkg::COLUMNS + int'(cursor_col_o));

  // The cursor reported in a result always lies on the screen.
  `TCW_ASSERT_IMP(a_cursor_on_screen, out_valid_o, col_ok && row_ok, "cursor outside the screen")

  // The linear position agrees with the column and row.
  `TCW_ASSERT_IMP(a_pos_consistent, out_valid_o, pos_ok, "cursor position mismatch")

  // One item at a time: an accepted item closes the input until it is done.
  `TCW_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "input reopened early")

  // A stalled result keeps its payload.
  `TCW_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cursor_pos_o) && $stable(cell_value_o), "stalled result changed")

endmodule

bind text_console_writer text_console_writer_sva u_text_console_writer_sva (.*);
